[hw/rtl/mono_downmix_linear_resampler_unit_assert.svh]
// Assertion macros shared by the checker of the mono downmix resampler.
`ifndef MONO_DOWNMIX_LINEAR_RESAMPLER_UNIT_ASSERT_SVH
`define MONO_DOWNMIX_LINEAR_RESAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on aclk and ignored while aresetn is low.
`define MDLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and ignored while aresetn is low.
`define MDLR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mdlr_pkg.sv]
// Package of shared types and constants for the mono downmix resampler.
`default_nettype none
package mdlr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int NUM_SAMPLES = 8;
    localparam int CNT_W       = 4;
    localparam int GAIN_W      = 17;
    localparam int STEP_CFG_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIX_GAIN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP    = 2'd2;

    localparam logic [CNT_W-1:0]      CHANNEL_COUNT_RST = 4'd2;
    localparam logic [GAIN_W-1:0]     MIX_GAIN_RST      = 17'd32768;
    localparam logic [STEP_CFG_W-1:0] PHASE_STEP_RST    = 20'd196608;

    localparam logic signed [SAMPLE_W-1:0] MONO_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MONO_MIN = 16'sh8000;

    // Mono word handed from the merging stage to the interpolator.
    typedef struct packed {
        logic                       vld;
        logic                       pkt_end;
        logic signed [SAMPLE_W-1:0] mono;
    } mdlr_mono_t;

    typedef enum logic [1:0] {
        INT_IDLE,
        INT_MUL,
        INT_ACC,
        INT_SCALE
    } mdlr_int_state_t;

endpackage
`default_nettype wire

[hw/rtl/mdlr_lane.sv]
// One channel lane: gates a channel sample by its enable and registers it.
`default_nettype none
module mdlr_lane (
    input  wire logic                                  aclk,
    input  wire logic                                  load,
    input  wire logic                                  lane_en,
    input  wire logic signed [mdlr_pkg::SAMPLE_W-1:0]  sample_in,
    output logic signed [mdlr_pkg::SAMPLE_W-1:0]       sample_out
);

    logic signed [mdlr_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [mdlr_pkg::SAMPLE_W-1:0] sample_next;

    always_comb begin
        sample_next = sample_reg;
        if (load) begin
            sample_next = lane_en ? sample_in : '0;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

    assign sample_out = sample_reg;

endmodule
`default_nettype wire

[hw/rtl/mdlr_merge.sv]
// Merging stage: sums the lanes, applies the mix gain and saturates to 16 bits.
`default_nettype none
module mdlr_merge #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_vld,
    input  wire logic                                  in_pkt_end,
    input  wire logic signed [mdlr_pkg::SAMPLE_W-1:0]  lane_data [MAX_CHANNELS],
    input  wire logic [mdlr_pkg::GAIN_W-1:0]           mix_gain,
    output mdlr_pkg::mdlr_mono_t                       mono_o,
    output logic                                       busy
);

    localparam int SUM_W  = mdlr_pkg::SAMPLE_W + $clog2(MAX_CHANNELS + 1);
    localparam int PROD_W = SUM_W + mdlr_pkg::GAIN_W + 1;
    localparam int SHR_W  = PROD_W - 16;

    logic                     sum_vld_reg;
    logic                     pkt1_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     prod_vld_reg;
    logic                     pkt2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SHR_W-1:0]  shr;
    logic                     hi_zero;
    logic                     hi_ones;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            sum_next = sum_next +
                {{(SUM_W - mdlr_pkg::SAMPLE_W){lane_data[i][mdlr_pkg::SAMPLE_W-1]}},
                 lane_data[i]};
        end
    end

    assign prod_next = sum_reg * $signed({1'b0, mix_gain});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            sum_vld_reg  <= in_vld;
            prod_vld_reg <= sum_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        pkt1_reg <= in_pkt_end;
        prod_reg <= prod_next;
        pkt2_reg <= pkt1_reg;
    end

    // Dropping the low 16 bits of a signed value rounds towards minus infinity.
    assign shr     = prod_reg[PROD_W-1:16];
    assign hi_zero = ~|shr[SHR_W-1:15];
    assign hi_ones = &shr[SHR_W-1:15];

    always_comb begin
        mono_o.vld     = prod_vld_reg;
        mono_o.pkt_end = pkt2_reg;
        if (!shr[SHR_W-1] && !hi_zero) begin
            mono_o.mono = mdlr_pkg::MONO_MAX;
        end else if (shr[SHR_W-1] && !hi_ones) begin
            mono_o.mono = mdlr_pkg::MONO_MIN;
        end else begin
            mono_o.mono = shr[15:0];
        end
    end

    assign busy = sum_vld_reg | prod_vld_reg;

endmodule
`default_nettype wire

[hw/rtl/mdlr_interp.sv]
// Interpolator: keeps the previous mono value and the output position, emits results.
`default_nettype none
module mdlr_interp #(
    parameter int PHASE_FRAC_BITS = 16,
    localparam int STEP_W = (PHASE_FRAC_BITS > mdlr_pkg::STEP_CFG_W) ?
                            PHASE_FRAC_BITS : mdlr_pkg::STEP_CFG_W
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire mdlr_pkg::mdlr_mono_t                  mono_i,
    input  wire logic [STEP_W-1:0]                     step,
    input  wire logic                                  m_tready,
    output logic                                       m_tvalid,
    output logic [mdlr_pkg::SAMPLE_W-1:0]              m_tdata,
    output logic                                       m_tlast,
    output logic                                       busy
);

    localparam int OFS_W  = STEP_W + 1;
    localparam int PROD_W = PHASE_FRAC_BITS + 18;
    localparam int V_W    = PHASE_FRAC_BITS + 18;
    localparam int SH     = PHASE_FRAC_BITS + 15;
    localparam int W_W    = V_W + 15;

    localparam logic [OFS_W-1:0]      ONE   = OFS_W'(1) << PHASE_FRAC_BITS;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(1) << SH;
    localparam logic signed [V_W-1:0] V_MIN = -V_MAX;
    localparam logic signed [W_W-1:0] BIAS  = (W_W'(1) << SH) - W_W'(1);

    mdlr_pkg::mdlr_int_state_t state_reg, state_next;

    logic signed [15:0]       prev_reg, prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [OFS_W-1:0]         ofs_reg, ofs_next;
    logic signed [15:0]       cur_reg, cur_next;
    logic                     pkt_reg, pkt_next;
    logic                     cnt_reg, cnt_next;
    logic [OFS_W-1:0]         ofs_add_reg, ofs_add_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [V_W-1:0]    v_reg, v_next;
    logic                     out_vld_reg, out_vld_next;
    logic [15:0]              out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    logic signed [16:0]              diff;
    logic signed [PHASE_FRAC_BITS:0] frac_s;
    logic signed [V_W-1:0]           v_base;
    logic signed [V_W-1:0]           v_raw;
    logic signed [W_W-1:0]           w;
    logic signed [W_W-1:0]           w_adj;
    logic                            last;

    assign diff   = {cur_reg[15], cur_reg} - {prev_reg[15], prev_reg};
    assign frac_s = $signed({1'b0, ofs_reg[PHASE_FRAC_BITS-1:0]});
    assign v_base = $signed({{2{prev_reg[15]}}, prev_reg, {PHASE_FRAC_BITS{1'b0}}});
    assign v_raw  = v_base + prod_reg;
    // Scaling by 32767 is a shift by 15 less one copy; the bias makes the shift truncate.
    assign w      = $signed({v_reg, 15'b0}) - $signed({{15{v_reg[V_W-1]}}, v_reg});
    assign w_adj  = w + (w[W_W-1] ? BIAS : '0);
    assign last   = cnt_reg || (ofs_add_reg >= ONE);

    always_comb begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        ofs_next       = ofs_reg;
        cur_next       = cur_reg;
        pkt_next       = pkt_reg;
        cnt_next       = cnt_reg;
        ofs_add_next   = ofs_add_reg;
        prod_next      = prod_reg;
        v_next         = v_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            mdlr_pkg::INT_IDLE: begin
                if (mono_i.vld) begin
                    cur_next = mono_i.mono;
                    pkt_next = mono_i.pkt_end;
                    if (have_prev_reg && (ofs_reg < ONE)) begin
                        cnt_next   = 1'b0;
                        state_next = mdlr_pkg::INT_MUL;
                    end else begin
                        // No result from this frame: store it, step the position back.
                        if (have_prev_reg) begin
                            ofs_next = ofs_reg - ONE;
                        end
                        prev_next      = mono_i.mono;
                        have_prev_next = 1'b1;
                        if (mono_i.pkt_end) begin
                            prev_next      = '0;
                            have_prev_next = 1'b0;
                            ofs_next       = '0;
                        end
                    end
                end
            end
            mdlr_pkg::INT_MUL: begin
                prod_next    = diff * frac_s;
                ofs_add_next = ofs_reg + {1'b0, step};
                state_next   = mdlr_pkg::INT_ACC;
            end
            mdlr_pkg::INT_ACC: begin
                if (v_raw > V_MAX) begin
                    v_next = V_MAX;
                end else if (v_raw < V_MIN) begin
                    v_next = V_MIN;
                end else begin
                    v_next = v_raw;
                end
                state_next = mdlr_pkg::INT_SCALE;
            end
            mdlr_pkg::INT_SCALE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next  = 1'b1;
                    out_data_next = w_adj[SH +: 16];
                    out_last_next = last;
                    if (last) begin
                        ofs_next       = (ofs_add_reg >= ONE) ? ofs_add_reg - ONE : '0;
                        prev_next      = cur_reg;
                        have_prev_next = 1'b1;
                        if (pkt_reg) begin
                            prev_next      = '0;
                            have_prev_next = 1'b0;
                            ofs_next       = '0;
                        end
                        state_next = mdlr_pkg::INT_IDLE;
                    end else begin
                        ofs_next   = ofs_add_reg;
                        cnt_next   = 1'b1;
                        state_next = mdlr_pkg::INT_MUL;
                    end
                end
            end
            default: begin
                state_next = mdlr_pkg::INT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mdlr_pkg::INT_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            ofs_reg       <= '0;
            cnt_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            ofs_reg       <= ofs_next;
            cnt_reg       <= cnt_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        pkt_reg      <= pkt_next;
        ofs_add_reg  <= ofs_add_next;
        prod_reg     <= prod_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign busy     = (state_reg != mdlr_pkg::INT_IDLE);

endmodule
`default_nettype wire

[hw/rtl/mono_downmix_linear_resampler_unit.sv]
// Top level of the mono downmix and linear-interpolation resampler.
//
//  Channel   Ports                          Word contents
//  input     s_tvalid/s_tready/s_tdata      one multichannel frame, eight Q1.15 samples
//            s_tuser, s_tlast               silent flag, packet end
//  result    m_tvalid/m_tready/m_tdata      one interpolated mono sample
//            m_tlast                        last result caused by the frame
//  config    cfg_wr_en/cfg_index/cfg_wdata  channel count, mix gain, phase step
//
// One frame is in flight at a time. s_tready falls after an accepted word and, for a frame
// with no result, rises again once the lane, sum and gain registers have passed it on.
// m_tvalid rises for the first result after the lane, sum and gain registers and the
// multiply, clamp and scale states; a second result passes those states again.
// Reset is synchronous on aresetn low and returns registers and position to defaults.
// A stalled result holds m_tdata; the next frame is taken while the last result waits.
`default_nettype none
module mono_downmix_linear_resampler_unit #(
    parameter int MAX_CHANNELS    = 8,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // sample_0 .. sample_7, sample_0 in bits 15:0
    input  wire logic [mdlr_pkg::NUM_SAMPLES*mdlr_pkg::SAMPLE_W-1:0] s_tdata,
    // silent
    input  wire logic                                  s_tuser,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // mono_out
    output logic [mdlr_pkg::SAMPLE_W-1:0]              m_tdata,
    output logic                                       m_tlast,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [mdlr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mdlr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int STEP_W = (PHASE_FRAC_BITS > mdlr_pkg::STEP_CFG_W) ?
                            PHASE_FRAC_BITS : mdlr_pkg::STEP_CFG_W;
    localparam logic [STEP_W-1:0] HALF_STEP = STEP_W'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic [mdlr_pkg::CNT_W-1:0] CNT_MAX = mdlr_pkg::CNT_W'(MAX_CHANNELS);

    logic [mdlr_pkg::CNT_W-1:0]      cnt_cfg_reg;
    logic [mdlr_pkg::GAIN_W-1:0]     gain_cfg_reg;
    logic [mdlr_pkg::STEP_CFG_W-1:0] step_cfg_reg;

    logic [mdlr_pkg::CNT_W-1:0] nch_eff;
    logic [STEP_W-1:0]          step_ext;
    logic [STEP_W-1:0]          step_eff;
    logic                       accept;
    logic                       lane_vld_reg;
    logic                       pkt_reg;
    logic                       merge_busy;
    logic                       int_busy;

    logic signed [mdlr_pkg::SAMPLE_W-1:0] lane_data [MAX_CHANNELS];
    mdlr_pkg::mdlr_mono_t                 mono;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_cfg_reg  <= mdlr_pkg::CHANNEL_COUNT_RST;
            gain_cfg_reg <= mdlr_pkg::MIX_GAIN_RST;
            step_cfg_reg <= mdlr_pkg::PHASE_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mdlr_pkg::CFG_CHANNEL_COUNT: cnt_cfg_reg  <= cfg_wdata[mdlr_pkg::CNT_W-1:0];
                mdlr_pkg::CFG_MIX_GAIN:      gain_cfg_reg <= cfg_wdata[mdlr_pkg::GAIN_W-1:0];
                mdlr_pkg::CFG_PHASE_STEP:    step_cfg_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A zero count means one channel; counts beyond the lanes use every lane.
    always_comb begin
        if (cnt_cfg_reg == '0) begin
            nch_eff = mdlr_pkg::CNT_W'(1);
        end else if (cnt_cfg_reg > CNT_MAX) begin
            nch_eff = CNT_MAX;
        end else begin
            nch_eff = cnt_cfg_reg;
        end
    end

    // The step never drops below half a frame, so a frame yields at most two results.
    assign step_ext = STEP_W'(step_cfg_reg);
    assign step_eff = (step_ext < HALF_STEP) ? HALF_STEP : step_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !(lane_vld_reg || merge_busy || int_busy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_vld_reg <= 1'b0;
        end else begin
            lane_vld_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pkt_reg <= s_tlast;
        end
    end

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        mdlr_lane u_lane (
            .aclk       (aclk),
            .load       (accept),
            .lane_en    ((mdlr_pkg::CNT_W'(i) < nch_eff) && !s_tuser),
            .sample_in  (s_tdata[i*mdlr_pkg::SAMPLE_W +: mdlr_pkg::SAMPLE_W]),
            .sample_out (lane_data[i])
        );
    end

    mdlr_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     (lane_vld_reg),
        .in_pkt_end (pkt_reg),
        .lane_data  (lane_data),
        .mix_gain   (gain_cfg_reg),
        .mono_o     (mono),
        .busy       (merge_busy)
    );

    mdlr_interp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_interp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mono_i   (mono),
        .step     (step_eff),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .busy     (int_busy)
    );

endmodule
`default_nettype wire

[hw/rtl/mdlr_checker.sv]
// Port-level checker for the resampler, bound to the top level.
`default_nettype none
`include "mono_downmix_linear_resampler_unit_assert.svh"
module mdlr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // A result waiting on the master side keeps its word unchanged.
    `MDLR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

    // While a frame still owes results, no new frame may be taken.
    `MDLR_ASSERT_IMP(a_no_accept_mid_run, m_tvalid && !m_tlast, !s_tready, "input ready while frame results remain")

    // Only one frame is in flight, so ready drops right after an accepted word.
    `MDLR_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input ready directly after accept")

    // Clamping to plus or minus one and scaling by 32767 never gives the most negative code.
    `MDLR_ASSERT_IMP(a_out_range, m_tvalid, m_tdata != 16'h8000, "result outside the scaled range")

endmodule

bind mono_downmix_linear_resampler_unit mdlr_checker u_mdlr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the mono downmix and linear-interpolation resampler.
`default_nettype none
module tb;
    import mdlr_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint FRAME_ONE      = 64'd1 << 16;

    typedef struct packed {
        logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] smp;
        logic                                 silent;
        logic                                 pkt_end;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono;
        logic                       last;
    } mono_word_t;

    // Tracks the register settings and the resampler position, and holds the
    // mono words that the frames accepted so far are due to produce.
    class resample_scoreboard;
        logic [CNT_W-1:0]      chan_count;
        logic [GAIN_W-1:0]     gain;
        logic [STEP_CFG_W-1:0] phase_inc;
        longint                prev_mono;
        bit                    have_prev;
        longint                position;
        mono_word_t            due_q[$];
        int                    errors;
        int                    frames;
        int                    results;

        function new();
            chan_count = CHANNEL_COUNT_RST;
            gain       = MIX_GAIN_RST;
            phase_inc  = PHASE_STEP_RST;
            prev_mono  = 0;
            have_prev  = 0;
            position   = 0;
            errors     = 0;
            frames     = 0;
            results    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CHANNEL_COUNT: chan_count = val[CNT_W-1:0];
                CFG_MIX_GAIN:      gain       = val[GAIN_W-1:0];
                CFG_PHASE_STEP:    phase_inc  = val[STEP_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Straight line between two mono values, clamped to one and scaled to 16 bits.
        function logic signed [SAMPLE_W-1:0] blend(longint a, longint b, longint frac);
            longint v;
            v = a * FRAME_ONE + (b - a) * frac;
            if (v > 32768 * FRAME_ONE)
                v = 32768 * FRAME_ONE;
            if (v < -32768 * FRAME_ONE)
                v = -32768 * FRAME_ONE;
            // Division truncates toward zero, as the scaling requires.
            return SAMPLE_W'((v * 32767) / (64'sd1 <<< 31));
        endfunction

        function void note_frame(frame_t f);
            longint     sum;
            longint     mono;
            longint     inc;
            int         nch;
            int         n;
            mono_word_t outs [2];
            frames++;
            nch = (chan_count == 0) ? 1 : (chan_count > NUM_SAMPLES) ? NUM_SAMPLES
                                                                     : int'(chan_count);
            inc = (phase_inc < FRAME_ONE / 2) ? FRAME_ONE / 2 : longint'(phase_inc);
            sum = 0;
            if (!f.silent) begin
                for (int i = 0; i < nch; i++)
                    sum += longint'($signed(f.smp[i]));
            end
            mono = (sum * longint'(gain)) >>> 16;
            if (mono > 32767)
                mono = 32767;
            if (mono < -32768)
                mono = -32768;
            if (have_prev) begin
                n = 0;
                while (n < 2 && position < FRAME_ONE) begin
                    outs[n].mono = blend(prev_mono, mono, position);
                    outs[n].last = 1'b0;
                    n++;
                    position += inc;
                end
                position = (position >= FRAME_ONE) ? position - FRAME_ONE : 0;
                for (int k = 0; k < n; k++) begin
                    outs[k].last = (k == n - 1);
                    due_q.insert(due_q.size(), outs[k]);
                end
            end
            prev_mono = mono;
            have_prev = 1;
            if (f.pkt_end) begin
                prev_mono = 0;
                have_prev = 0;
                position  = 0;
            end
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] data, logic last);
            mono_word_t want;
            results++;
            if (due_q.size() == 0) begin
                $error("unexpected word: mono_out=%0d run_last=%0b", $signed(data), last);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (want.mono !== data) begin
                $error("mono_out: expected %0d, got %0d", want.mono, $signed(data));
                errors++;
            end
            if (want.last !== last) begin
                $error("run_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [NUM_SAMPLES*SAMPLE_W-1:0]      s_tdata;
    logic                                 s_tuser;
    logic                                 s_tlast;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [SAMPLE_W-1:0]                  m_tdata;
    logic                                 m_tlast;
    logic                                 cfg_wr_en;
    logic [CFG_INDEX_W-1:0]               cfg_index;
    logic [CFG_DATA_W-1:0]                cfg_wdata;

    resample_scoreboard sb;
    bit                 quiet_mode;
    bit                 stall_request;
    bit                 stall_done;
    int                 idle_cycles;
    int                 settings_used;

    mono_downmix_linear_resampler_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Ends the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic frame_t mk_frame(logic [SAMPLE_W-1:0] even_v, logic [SAMPLE_W-1:0] odd_v,
                                        logic silent, logic pkt_end);
        frame_t f;
        for (int i = 0; i < NUM_SAMPLES; i++)
            f.smp[i] = (i % 2) ? odd_v : even_v;
        f.silent  = silent;
        f.pkt_end = pkt_end;
        return f;
    endfunction

    function automatic frame_t rand_frame(logic pkt_end);
        frame_t f;
        f = '0;
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            case ($urandom_range(0, 7))
                0:       f.smp[i] = 16'h8000;
                1:       f.smp[i] = 16'h7FFF;
                2:       f.smp[i] = f.smp[0];
                default: f.smp[i] = SAMPLE_W'($urandom);
            endcase
        end
        f.silent  = ($urandom_range(0, 7) == 0);
        f.pkt_end = pkt_end;
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= f.smp;
        s_tuser  <= f.silent;
        s_tlast  <= f.pkt_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(f);
    endtask

    // Lets the block drain completely, including frames that produce no word.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(int cnt, int gain, int inc);
        settle();
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(cnt));
        write_reg(CFG_MIX_GAIN, CFG_DATA_W'(gain));
        write_reg(CFG_PHASE_STEP, CFG_DATA_W'(inc));
        settings_used++;
    endtask

    // Mostly packets of a few frames each, with the occasional one-frame packet.
    task automatic run_phase(int cnt, int gain, int inc, int n_frames, bit quiet);
        int frames_left;
        set_regs(cnt, gain, inc);
        quiet_mode  = quiet;
        frames_left = 0;
        for (int k = 0; k < n_frames; k++) begin
            if (frames_left == 0)
                frames_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            send_frame(rand_frame(frames_left == 1));
            frames_left--;
        end
    endtask

    // Result side: random back-pressure per word, and one long hold on request.
    initial begin
        stall_done = 0;
        wait (aresetn === 1'b1);
        forever begin
            int gap;
            if (stall_request && !stall_done) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stall_done = 1;
            end
            gap = quiet_mode ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        quiet_mode    = 0;
        stall_request = 0;
        settings_used = 1;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a step of three frames, so positions often lie past the frame.
        send_frame(mk_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h1234, 16'h8000, 1'b1, 1'b0));
        send_frame(mk_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h0001, 16'hFFFF, 1'b0, 1'b0));
        send_frame(mk_frame(16'h4000, 16'hC000, 1'b0, 1'b1));
        send_frame(mk_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b1));

        // All eight channels at full swing with a step below one frame.
        set_regs(8, 8192, 40000);
        send_frame(mk_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0));
        send_frame(mk_frame(16'h0000, 16'h0000, 1'b0, 1'b0));
        send_frame(mk_frame(16'hFFFF, 16'h0001, 1'b0, 1'b1));

        // Gain too large for the count, so the mix saturates; step raised to one half.
        set_regs(4, 65536, 20000);
        send_frame(mk_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h8000, 1'b0, 1'b0));
        send_frame(mk_frame(16'h8000, 16'h8000, 1'b0, 1'b1));

        stall_request = 1;
        run_phase(1, 65536, 32768, 100, 0);
        run_phase(8, 8192, 786432, 100, 1);
        run_phase(2, 32768, 65536, 100, 0);
        run_phase(0, 65536, 12000, 100, 0);
        run_phase(15, 131071, 1048575, 100, 1);
        run_phase(3, 21845, 60211, 100, 0);
        run_phase(8, 65536, 50000, 100, 0);
        run_phase(5, 0, 0, 100, 1);
        run_phase($urandom_range(0, 15), $urandom_range(0, 131071),
                  $urandom_range(0, 1048575), 100, 0);
        run_phase($urandom_range(1, 8), $urandom_range(0, 65536),
                  $urandom_range(32768, 786432), 100, 0);
        settle();

        if (sb.due_q.size() != 0) begin
            $error("%0d expected words never arrived", sb.due_q.size());
            sb.errors++;
        end
        $display("Run covered %0d frames under %0d register settings and checked %0d words.",
                 sb.frames, settings_used, sb.results);
        $display("Included packets, silent frames, mix saturation, step clamping and a long hold.");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
